[hdl/meter_reading_delta_packer_assert.svh]
// ----------------------------------------------------------------------------
// meter_reading_delta_packer assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef METER_READING_DELTA_PACKER_ASSERT_SVH
`define METER_READING_DELTA_PACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MRDP_ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MRDP_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mrdp_pkg.sv]
// ----------------------------------------------------------------------------
// mrdp_pkg
// Types, constants and the bcd conversion shared by the delta packer modules.
// ----------------------------------------------------------------------------
package mrdp_pkg;

  // eight bcd digits with nibbles up to 15 stay below 2^28
  localparam int VALUE_W = 28;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;
  localparam int WORD_W  = 32;
  localparam int DIGITS  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [WORD_W-1:0]  word_t;

  localparam word_t MISSING_BCD    = 32'hFFFF_FFFF;
  localparam word_t MISSING_WORD   = 32'hFFFF_FFFF;
  localparam word_t DELTA_MISSING  = 32'h0000_FFFF;
  localparam word_t DELTA_SATURATE = 32'h0000_FFFE;

  // weight of each nibble, least significant first
  localparam value_t DIGIT_WEIGHT [DIGITS] = '{
    28'd1, 28'd10, 28'd100, 28'd1000,
    28'd10000, 28'd100000, 28'd1000000, 28'd10000000
  };

  // one classified reading on its way from front to back
  typedef struct packed {
    value_t             value;
    logic               missing;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic               last;
  } entry_t;

  // nibbles weigh their raw value, even above nine
  function automatic value_t bcd_to_bin(input word_t bcd);
    value_t acc;
    acc = '0;
    for (int i = 0; i < DIGITS; i++) begin
      acc = acc + value_t'(bcd[4*i +: 4]) * DIGIT_WEIGHT[i];
    end
    return acc;
  endfunction

endpackage

[hdl/mrdp_front.sv]
// ----------------------------------------------------------------------------
// mrdp_front
// Accepts readings, tracks the frame position and converts bcd to binary.
// ----------------------------------------------------------------------------
module mrdp_front
  import mrdp_pkg::*;
#(
  parameter int MAX_READINGS = 24
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  word_t  reading_bcd,
  input  logic   frame_last,
  input  logic   queue_full,
  output logic   push,
  output entry_t push_entry
);

  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] count_next;
  logic               last_next;

  // handshake toward the queue
  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // frame position and forced end of an overlong frame
  always_comb begin
    count_next = frame_count + COUNT_W'(1);
    last_next  = frame_last || (count_next >= COUNT_W'(MAX_READINGS));
  end

  // classified entry
  always_comb begin
    push_entry.missing  = (reading_bcd == MISSING_BCD);
    push_entry.value    = push_entry.missing ? '0 : bcd_to_bin(reading_bcd);
    push_entry.position = frame_count[POS_W-1:0];
    push_entry.count    = count_next;
    push_entry.last     = last_next;
  end

  // frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (push) begin
      frame_count <= last_next ? '0 : count_next;
    end
  end

endmodule

[hdl/mrdp_queue.sv]
// ----------------------------------------------------------------------------
// mrdp_queue
// Short queue between the front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module mrdp_queue
  import mrdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   not_empty
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  // status
  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_entry = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

[hdl/mrdp_back.sv]
// ----------------------------------------------------------------------------
// mrdp_back
// Applies the reference and delta rules and holds the result register.
// ----------------------------------------------------------------------------
module mrdp_back
  import mrdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               delta_mode,
  input  logic               not_empty,
  input  entry_t             entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output word_t              data_word,
  output word_t              reference_value,
  output logic [POS_W-1:0]   reference_position,
  output logic               reference_found,
  output logic [COUNT_W-1:0] reading_count,
  output logic               result_last
);

  logic             have_reference;
  value_t           reference_store;
  logic [POS_W-1:0] reference_index;
  value_t           previous_value;

  logic             take;
  logic             found_next;
  value_t           store_next;
  logic [POS_W-1:0] index_next;
  value_t           previous_next;
  value_t           diff;
  word_t            word_next;

  // move an entry when the result register is free or being drained
  assign pop = not_empty && (!out_valid || out_ready);

  // reference and delta rules
  always_comb begin
    take          = !entry.missing && !have_reference;
    found_next    = have_reference || take;
    store_next    = take ? entry.value : reference_store;
    index_next    = take ? entry.position : reference_index;
    previous_next = previous_value;
    diff          = previous_value - entry.value;
    if (take) begin
      previous_next = entry.value;
      word_next     = delta_mode ? '0 : WORD_W'(entry.value);
    end else if (delta_mode) begin
      if (entry.missing) begin
        word_next = DELTA_MISSING;
      end else if (previous_value < entry.value) begin
        word_next = '0;
      end else begin
        previous_next = entry.value;
        word_next = (WORD_W'(diff) > DELTA_SATURATE) ? DELTA_SATURATE : WORD_W'(diff);
      end
    end else begin
      word_next = entry.missing ? MISSING_WORD : WORD_W'(entry.value);
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_reference  <= 1'b0;
      reference_store <= '0;
      reference_index <= '0;
      previous_value  <= '0;
    end else if (pop) begin
      have_reference  <= found_next && !entry.last;
      reference_store <= store_next;
      reference_index <= index_next;
      previous_value  <= previous_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      data_word          <= word_next;
      reference_value    <= found_next ? WORD_W'(store_next) : '0;
      reference_position <= found_next ? index_next : '0;
      reference_found    <= found_next;
      reading_count      <= entry.count;
      result_last        <= entry.last;
    end
  end

endmodule

[hdl/meter_reading_delta_packer.sv]
// ----------------------------------------------------------------------------
// meter_reading_delta_packer
// Packs a frame of bcd meter readings into absolute words or reference plus
// saturated 16-bit decreases.
// ----------------------------------------------------------------------------
//  channel  | signals                         | moves
//  ---------+---------------------------------+-------------------------------
//  in       | in_valid / in_ready             | one reading per transaction
//  out      | out_valid / out_ready           | one result per transaction
//  cfg      | cfg_write_en / cfg_write_data   | delta_mode, no wait
//
//  One reading per cycle sustained while out_ready is high; a taken reading
//  goes through a queue slot and then the result register (bcd conversion
//  ahead of the queue, delta rules into the result register).
//  Reset clears the frame counter, the two-entry queue, the reference state
//  and delta_mode. When out_ready stays low the queue fills and in_ready
//  drops after two more readings; a reading in the result register and two
//  in the queue are held without loss.
// ----------------------------------------------------------------------------
`include "meter_reading_delta_packer_assert.svh"

module meter_reading_delta_packer
  import mrdp_pkg::*;
#(
  parameter int MAX_READINGS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] reading_bcd,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] data_word,
  output logic [31:0] reference_value,
  output logic [4:0]  reference_position,
  output logic        reference_found,
  output logic [5:0]  reading_count,
  output logic        result_last
);

  logic   delta_mode;
  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   pop;
  entry_t pop_entry;
  logic   not_empty;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      delta_mode <= 1'b0;
    end else if (cfg_write_en) begin
      delta_mode <= cfg_write_data;
    end
  end

  // front: accept and classify
  mrdp_front #(
    .MAX_READINGS (MAX_READINGS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .reading_bcd (reading_bcd),
    .frame_last  (frame_last),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // queue between front and back
  mrdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (not_empty)
  );

  // back: reference and delta rules
  mrdp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .delta_mode         (delta_mode),
    .not_empty          (not_empty),
    .entry              (pop_entry),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .data_word          (data_word),
    .reference_value    (reference_value),
    .reference_position (reference_position),
    .reference_found    (reference_found),
    .reading_count      (reading_count),
    .result_last        (result_last)
  );

  // checks
  `MRDP_ASSERT_IMPLIES(a_no_ref_zero, clk, rst, out_valid && !reference_found,
    reference_value == '0 && reference_position == '0, "reference fields set without reference")
  `MRDP_ASSERT_IMPLIES(a_count_bound, clk, rst, out_valid,
    reading_count != '0 && reading_count <= 6'(MAX_READINGS), "reading count out of range")
  `MRDP_ASSERT_IMPLIES(a_delta_narrow, clk, rst, out_valid && delta_mode,
    data_word[31:16] == '0, "delta word wider than 16 bits")
  `MRDP_ASSERT_NEXT(a_last_restarts, clk, rst, out_valid && out_ready && result_last && pop,
    reading_count == 6'd1, "frame did not restart after last result")

endmodule
